FILE: src/lcbc_pkg.sv
// Shared constants, types and the decision function of the line crossing border classifier.
package lcbc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  localparam int PIX_W      = 8;
  localparam int CNT_W      = 11;
  localparam int SUM_W      = 20;
  localparam int THR_W      = 10;
  localparam int CTR_W      = 10;
  localparam int DEC_W      = 2;
  localparam int DIM_W      = 11;
  localparam int SIDE_W     = 9;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [PIX_W-1:0] SET_VALUE = 8'hFF;
  localparam int BAND_SPAN = 4;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SIDE_OFFSET     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_COUNT_THRESHOLD = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEFAULT_CENTER  = 3'd4;

  localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH     = 11'd120;
  localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT    = 11'd120;
  localparam logic [SIDE_W-1:0] RST_SIDE_OFFSET     = 9'd10;
  localparam logic [THR_W-1:0]  RST_COUNT_THRESHOLD = 10'd4;
  localparam logic [CTR_W-1:0]  RST_DEFAULT_CENTER  = 10'd60;

  // Summary queue between the pixel front end and the result back end.
  // The depth must be a power of two so that the pointers wrap on their own.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int DIV_STEPS   = SUM_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  typedef enum logic [DEC_W-1:0] {
    DEC_STOP,
    DEC_FORWARD,
    DEC_CROSSING,
    DEC_END
  } decision_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] top_count;
    logic [SUM_W-1:0] top_sum;
    logic [CNT_W-1:0] bottom_count;
    logic [CNT_W-1:0] left_count;
    logic [CNT_W-1:0] right_count;
  } frame_sum_t;

  // Later rules override earlier ones.
  function automatic decision_t decide(frame_sum_t s, logic [THR_W-1:0] thr);
    logic [CNT_W:0] t_ext;
    logic [CNT_W:0] t_band;
    logic [CNT_W:0] up;
    logic [CNT_W:0] dn;
    logic [CNT_W:0] lc;
    logic [CNT_W:0] rc;
    decision_t      d;
    t_ext  = (CNT_W+1)'(thr);
    t_band = t_ext + (CNT_W+1)'(BAND_SPAN);
    up     = {1'b0, s.top_count};
    dn     = {1'b0, s.bottom_count};
    lc     = {1'b0, s.left_count};
    rc     = {1'b0, s.right_count};
    d      = DEC_STOP;
    if (up > t_ext && lc < t_ext && rc < t_ext) begin
      d = DEC_FORWARD;
    end
    if ((lc > t_ext && rc > t_ext && up > t_ext) ||
        (dn > t_ext && ((lc > t_ext && lc < t_band) || (rc > t_ext && rc < t_band)))) begin
      d = DEC_CROSSING;
    end
    if (up == '0 && lc == '0 && rc == '0) begin
      d = DEC_END;
    end
    return d;
  endfunction

endpackage

FILE: src/lcbc_ifs.sv
// Valid/ready channel interfaces for pixels in and frame results out.
interface lcbc_pixel_if import lcbc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface lcbc_result_if import lcbc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CTR_W-1:0] center_x;
  logic [DEC_W-1:0] decision;

  modport source (output valid, output center_x, output decision, input ready);
  modport sink   (input valid, input center_x, input decision, output ready);
endinterface

FILE: src/lcbc_front.sv
// Pixel front end: tracks the raster position and accumulates the border counts of a frame.
module lcbc_front import lcbc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  lcbc_pixel_if.sink        px,
  input  logic [DIM_W-1:0]  frame_width,
  input  logic [DIM_W-1:0]  frame_height,
  input  logic [SIDE_W-1:0] side_offset,
  output logic              push,
  output frame_sum_t        push_data,
  input  logic              push_ready
);

  logic [COL_W-1:0] x_r;
  logic [ROW_W-1:0] y_r;
  logic [CNT_W-1:0] top_count_r;
  logic [SUM_W-1:0] top_sum_r;
  logic [CNT_W-1:0] bottom_count_r;
  logic [CNT_W-1:0] left_count_r;
  logic [CNT_W-1:0] right_count_r;

  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] hm1;
  logic             accept;
  logic             is_set;
  logic             last_col;
  logic             last_row;
  logic             side_ok;
  logic [COL_W-1:0] right_col;
  frame_sum_t       sum_nxt;

  always_comb begin
    // Last column and row in use, with the geometry clamped to the supported range.
    if (frame_width == '0) begin
      wm1 = '0;
    end else if (frame_width > DIM_W'(MAX_WIDTH)) begin
      wm1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      wm1 = COL_W'(frame_width - 1'b1);
    end
    if (frame_height == '0) begin
      hm1 = '0;
    end else if (frame_height > DIM_W'(MAX_HEIGHT)) begin
      hm1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hm1 = ROW_W'(frame_height - 1'b1);
    end

    px.ready  = push_ready;
    accept    = px.valid && push_ready;
    is_set    = px.pixel == SET_VALUE;
    last_col  = x_r >= wm1;
    last_row  = y_r >= hm1;
    side_ok   = side_offset <= wm1;
    right_col = wm1 - COL_W'(side_offset);

    sum_nxt.top_count    = top_count_r;
    sum_nxt.top_sum      = top_sum_r;
    sum_nxt.bottom_count = bottom_count_r;
    sum_nxt.left_count   = left_count_r;
    sum_nxt.right_count  = right_count_r;
    if (is_set) begin
      if (y_r == '0) begin
        sum_nxt.top_count = top_count_r + 1'b1;
        sum_nxt.top_sum   = top_sum_r + SUM_W'(x_r);
      end
      if (last_row) begin
        sum_nxt.bottom_count = bottom_count_r + 1'b1;
      end
      // Both side columns exist only when the offset falls inside the row.
      if (side_ok && x_r == COL_W'(side_offset)) begin
        sum_nxt.left_count = left_count_r + 1'b1;
      end
      if (side_ok && x_r == right_col) begin
        sum_nxt.right_count = right_count_r + 1'b1;
      end
    end

    push      = accept && last_col && last_row;
    push_data = sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r            <= '0;
      y_r            <= '0;
      top_count_r    <= '0;
      top_sum_r      <= '0;
      bottom_count_r <= '0;
      left_count_r   <= '0;
      right_count_r  <= '0;
    end else if (accept) begin
      if (last_col && last_row) begin
        x_r            <= '0;
        y_r            <= '0;
        top_count_r    <= '0;
        top_sum_r      <= '0;
        bottom_count_r <= '0;
        left_count_r   <= '0;
        right_count_r  <= '0;
      end else begin
        if (last_col) begin
          x_r <= '0;
          y_r <= y_r + 1'b1;
        end else begin
          x_r <= x_r + 1'b1;
        end
        top_count_r    <= sum_nxt.top_count;
        top_sum_r      <= sum_nxt.top_sum;
        bottom_count_r <= sum_nxt.bottom_count;
        left_count_r   <= sum_nxt.left_count;
        right_count_r  <= sum_nxt.right_count;
      end
    end
  end

endmodule

FILE: src/lcbc_queue.sv
// Short queue of frame summaries between the front end and the back end.
module lcbc_queue import lcbc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  frame_sum_t push_data,
  output logic       push_ready,
  input  logic       pop,
  output logic       pop_valid,
  output frame_sum_t pop_data
);

  frame_sum_t        entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  always_comb begin
    push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
    pop_valid  = count_r != '0;
    pop_data   = entry_r[rd_ptr_r];
    do_push    = push && push_ready;
    do_pop     = pop && pop_valid;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_ready)
    else $error("frame summary pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond its depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue fill count did not follow a lone push");
`endif

endmodule

FILE: src/lcbc_back.sv
// Result back end: serial divider for the mean top x, decision rules and output register.
module lcbc_back import lcbc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  input  frame_sum_t        pop_data,
  output logic              pop,
  input  logic [THR_W-1:0]  count_threshold,
  input  logic [CTR_W-1:0]  default_center,
  lcbc_result_if.source     res
);

  back_state_t          state_r;
  back_state_t          state_nxt;
  logic [CNT_W-1:0]     div_r;
  logic [CNT_W-1:0]     div_nxt;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     rem_nxt;
  logic [SUM_W-1:0]     dq_r;
  logic [SUM_W-1:0]     dq_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_CNT_W-1:0] cnt_nxt;
  logic [CTR_W-1:0]     center_r;
  logic [CTR_W-1:0]     center_nxt;
  decision_t            decision_r;
  decision_t            decision_nxt;
  logic [CNT_W:0]       shifted;
  logic [CNT_W:0]       diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    dq_r       <= dq_nxt;
    cnt_r      <= cnt_nxt;
    center_r   <= center_nxt;
    decision_r <= decision_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    div_nxt      = div_r;
    rem_nxt      = rem_r;
    dq_nxt       = dq_r;
    cnt_nxt      = cnt_r;
    center_nxt   = center_r;
    decision_nxt = decision_r;
    pop          = 1'b0;
    res.valid    = 1'b0;

    // One restoring step: bring down the next dividend bit and try to subtract.
    shifted = {rem_r, dq_r[SUM_W-1]};
    diff    = shifted - {1'b0, div_r};

    unique case (state_r)
      BK_IDLE: begin
        if (pop_valid) begin
          pop          = 1'b1;
          decision_nxt = decide(pop_data, count_threshold);
          div_nxt      = pop_data.top_count;
          dq_nxt       = pop_data.top_sum;
          rem_nxt      = '0;
          cnt_nxt      = DIV_CNT_W'(DIV_STEPS - 1);
          if (pop_data.top_count == '0) begin
            center_nxt = default_center;
            state_nxt  = BK_OUT;
          end else begin
            state_nxt  = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        if (shifted >= {1'b0, div_r}) begin
          rem_nxt = diff[CNT_W-1:0];
          dq_nxt  = {dq_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[CNT_W-1:0];
          dq_nxt  = {dq_r[SUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          center_nxt = dq_nxt[CTR_W-1:0];
          state_nxt  = BK_OUT;
        end
      end
      BK_OUT: begin
        res.valid = 1'b1;
        if (res.ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign res.center_x = center_r;
  assign res.decision = decision_r;

`ifndef SYNTHESIS
  a_empty_top_skips_div: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && pop_data.top_count == '0) |=> state_r == BK_OUT)
    else $error("empty top row did not go straight to the result");

  a_div_countdown: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV && cnt_r != '0) |=> state_r == BK_DIV && cnt_r == $past(cnt_r) - 1'b1)
    else $error("divider step counter out of sequence");

  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV && cnt_r == '0) |=> rem_r < div_r)
    else $error("division finished with remainder not below divisor");
`endif

endmodule

FILE: src/line_crossing_border_classifier.sv
// Top level: configuration registers, pixel front end, summary queue and result back end.
// Pixels are taken at one per cycle; the front end stalls only when the two-entry summary
// queue is full. The back end pops a frame summary when idle and goes straight to its
// output state when the top row is empty, otherwise through the 20-step serial divider.
// It holds one frame at a time and pops another summary only after the result is taken.
// Synchronous active-low reset clears the counters and queue and reloads register defaults.
module line_crossing_border_classifier import lcbc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  lcbc_pixel_if.sink            in_px,
  lcbc_result_if.source         out_res
);

  logic [DIM_W-1:0]  frame_width_r;
  logic [DIM_W-1:0]  frame_height_r;
  logic [SIDE_W-1:0] side_offset_r;
  logic [THR_W-1:0]  count_threshold_r;
  logic [CTR_W-1:0]  default_center_r;

  logic       push;
  logic       push_ready;
  frame_sum_t push_data;
  logic       pop;
  logic       pop_valid;
  frame_sum_t pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r     <= RST_FRAME_WIDTH;
      frame_height_r    <= RST_FRAME_HEIGHT;
      side_offset_r     <= RST_SIDE_OFFSET;
      count_threshold_r <= RST_COUNT_THRESHOLD;
      default_center_r  <= RST_DEFAULT_CENTER;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FRAME_WIDTH:     frame_width_r     <= cfg_wdata[DIM_W-1:0];
        CFG_FRAME_HEIGHT:    frame_height_r    <= cfg_wdata[DIM_W-1:0];
        CFG_SIDE_OFFSET:     side_offset_r     <= cfg_wdata[SIDE_W-1:0];
        CFG_COUNT_THRESHOLD: count_threshold_r <= cfg_wdata[THR_W-1:0];
        CFG_DEFAULT_CENTER:  default_center_r  <= cfg_wdata[CTR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lcbc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .px           (in_px),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .side_offset  (side_offset_r),
    .push         (push),
    .push_data    (push_data),
    .push_ready   (push_ready)
  );

  lcbc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  lcbc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_data        (pop_data),
    .pop             (pop),
    .count_threshold (count_threshold_r),
    .default_center  (default_center_r),
    .res             (out_res)
  );

endmodule
